// ----- src/protobuf_field_extractor_macros.svh -----
// Assertion macros for the field extractor.
`ifndef PROTOBUF_FIELD_EXTRACTOR_MACROS_SVH
`define PROTOBUF_FIELD_EXTRACTOR_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define PBFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define PBFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pbfe_pkg.sv -----
// Shared widths, status codes and payload types of the field extractor.
package pbfe_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 24;
	localparam int FIELD_W  = 29;
	localparam int STATUS_W = 2;

	localparam logic [LEN_W-1:0]   MAX_MESSAGE_BYTES = 24'hFF_FFFF;
	localparam logic [FIELD_W-1:0] TARGET_RESET      = 29'd3;

	localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERRUN  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADWIRE  = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0]  message_length;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    payload_offset;
		logic [LEN_W-1:0]    payload_length;
	} result_t;

endpackage

// ----- src/pbfe_ifs.sv -----
// Valid/ready channel interfaces: message bytes, results, target register writes.
interface pbfe_msg_if;
	logic                          valid;
	logic                          ready;
	logic [pbfe_pkg::BYTE_W-1:0]   data_byte;
	logic [pbfe_pkg::LEN_W-1:0]    message_length;

	modport source (output valid, output data_byte, output message_length, input ready);
	modport sink   (input valid, input data_byte, input message_length, output ready);
endinterface

interface pbfe_res_if;
	logic                          valid;
	logic                          ready;
	logic [pbfe_pkg::STATUS_W-1:0] status;
	logic [pbfe_pkg::LEN_W-1:0]    payload_offset;
	logic [pbfe_pkg::LEN_W-1:0]    payload_length;

	modport source (output valid, output status, output payload_offset,
		output payload_length, input ready);
	modport sink   (input valid, input status, input payload_offset,
		input payload_length, output ready);
endinterface

interface pbfe_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pbfe_pkg::FIELD_W-1:0]  target_field;

	modport source (output valid, output target_field, input ready);
	modport sink   (input valid, input target_field, output ready);
endinterface

// ----- src/pbfe_core.sv -----
// Parser state and per-byte next-state/result logic of the field extractor.
module pbfe_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  pbfe_pkg::item_t              item,
	input  logic [pbfe_pkg::FIELD_W-1:0] target,
	output logic                         res_v,
	output pbfe_pkg::result_t            res
);

	localparam logic [2:0] PH_KEY     = 3'd0;
	localparam logic [2:0] PH_LEN     = 3'd1;
	localparam logic [2:0] PH_SKIPVAR = 3'd2;
	localparam logic [2:0] PH_SKIPN   = 3'd3;
	localparam logic [2:0] PH_DONE    = 3'd4;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_I64    = 3'd1;
	localparam logic [2:0] WT_LEN    = 3'd2;
	localparam logic [2:0] WT_I32    = 3'd5;

	localparam int ACC_W = 35; // key bits 34:0 hold wire type and a 32-bit field number
	localparam logic [3:0] GRP_END = 4'd10;

	logic [pbfe_pkg::LEN_W-1:0] pos_q, pos_n;
	logic [2:0]                 ph_q, ph_n;
	logic [ACC_W-1:0]           acc_q, acc_n, acc_a, sh;
	logic [3:0]                 grp_q, grp_n, grp_a;
	logic                       hi_q, hi_n, hi_a, hi_b;
	logic [31:0]                fn_q, fn_n, key_fn;
	logic [pbfe_pkg::LEN_W-1:0] skip_q, skip_n, skip_d;

	logic [pbfe_pkg::LEN_W-1:0] msg_len, q, rem;
	logic [6:0]                 b7;
	logic                       beyond, at_end, term, overrun;

	assign b7      = item.data_byte[6:0];
	assign msg_len = (item.message_length > pbfe_pkg::MAX_MESSAGE_BYTES) ?
		pbfe_pkg::MAX_MESSAGE_BYTES : item.message_length;
	assign beyond  = (pos_q >= msg_len);
	assign q       = pos_q + 24'd1;
	assign at_end  = (q >= msg_len);
	assign term    = !item.data_byte[7] || at_end;
	assign rem     = msg_len - q;
	assign key_fn  = acc_a[ACC_W-1:3];
	assign skip_d  = (skip_q != '0) ? skip_q - 24'd1 : skip_q;

	// 7-bit group placed at its shift; bits past 34 only set the sticky flag
	always_comb begin
		sh   = '0;
		hi_b = 1'b0;
		unique case (grp_q)
			4'd0: sh = ACC_W'(b7);
			4'd1: sh = ACC_W'(b7) << 7;
			4'd2: sh = ACC_W'(b7) << 14;
			4'd3: sh = ACC_W'(b7) << 21;
			4'd4: sh = ACC_W'(b7) << 28;
			4'd5, 4'd6, 4'd7, 4'd8: hi_b = |b7;
			4'd9: hi_b = b7[0];
			default: ;
		endcase
		acc_a = acc_q | sh;
		hi_a  = hi_q | hi_b;
		grp_a = (grp_q < GRP_END) ? grp_q + 4'd1 : grp_q;
	end

	assign overrun = hi_a || (|acc_a[ACC_W-1:pbfe_pkg::LEN_W]) ||
		(acc_a[pbfe_pkg::LEN_W-1:0] > rem);

	always_comb begin
		pos_n  = pos_q;
		ph_n   = ph_q;
		acc_n  = acc_q;
		grp_n  = grp_q;
		hi_n   = hi_q;
		fn_n   = fn_q;
		skip_n = skip_q;
		res_v  = 1'b0;
		res    = '{status: pbfe_pkg::ST_NOTFOUND, payload_offset: '0, payload_length: '0};

		if (beyond) begin
			// byte past the message end: close it out
			res_v = (ph_q != PH_DONE);
		end else begin
			unique case (ph_q)
				PH_KEY: begin
					acc_n = acc_a;
					grp_n = grp_a;
					hi_n  = hi_a;
					if (term) begin
						acc_n = '0;
						grp_n = '0;
						hi_n  = 1'b0;
						fn_n  = key_fn;
						unique case (acc_a[2:0])
							WT_LEN: begin
								ph_n = PH_LEN;
								// key ending on the last byte: zero-length payload
								if (at_end && key_fn == 32'(target)) begin
									res_v = 1'b1;
									res   = '{status: pbfe_pkg::ST_FOUND,
										payload_offset: q, payload_length: '0};
								end else if (at_end) begin
									ph_n = PH_KEY;
								end
							end
							WT_VARINT: ph_n = PH_SKIPVAR;
							WT_I32: begin
								skip_n = 24'd4;
								ph_n   = PH_SKIPN;
							end
							WT_I64: begin
								skip_n = 24'd8;
								ph_n   = PH_SKIPN;
							end
							default: begin
								res_v = 1'b1;
								res   = '{status: pbfe_pkg::ST_BADWIRE,
									payload_offset: '0, payload_length: '0};
							end
						endcase
					end
				end
				PH_LEN: begin
					acc_n = acc_a;
					grp_n = grp_a;
					hi_n  = hi_a;
					if (term) begin
						acc_n = '0;
						grp_n = '0;
						hi_n  = 1'b0;
						if (overrun) begin
							res_v = 1'b1;
							res   = '{status: pbfe_pkg::ST_OVERRUN,
								payload_offset: '0, payload_length: '0};
						end else if (fn_q == 32'(target)) begin
							res_v = 1'b1;
							res   = '{status: pbfe_pkg::ST_FOUND, payload_offset: q,
								payload_length: acc_a[pbfe_pkg::LEN_W-1:0]};
						end else begin
							skip_n = acc_a[pbfe_pkg::LEN_W-1:0];
							ph_n   = (acc_a[pbfe_pkg::LEN_W-1:0] == '0) ? PH_KEY : PH_SKIPN;
						end
					end
				end
				PH_SKIPVAR: begin
					if (!item.data_byte[7])
						ph_n = PH_KEY;
				end
				PH_SKIPN: begin
					skip_n = skip_d;
					if (skip_d == '0)
						ph_n = PH_KEY;
				end
				default: ;
			endcase

			if (res_v)
				ph_n = PH_DONE;

			if (at_end) begin
				if (!res_v && ph_q != PH_DONE)
					res_v = 1'b1;
			end else begin
				pos_n = q;
			end
		end

		// message closed: rearm
		if (beyond || at_end) begin
			pos_n  = '0;
			ph_n   = PH_KEY;
			acc_n  = '0;
			grp_n  = '0;
			hi_n   = 1'b0;
			fn_n   = '0;
			skip_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ph_q   <= PH_KEY;
			acc_q  <= '0;
			grp_q  <= '0;
			hi_q   <= 1'b0;
			fn_q   <= '0;
			skip_q <= '0;
		end else if (step) begin
			pos_q  <= pos_n;
			ph_q   <= ph_n;
			acc_q  <= acc_n;
			grp_q  <= grp_n;
			hi_q   <= hi_n;
			fn_q   <= fn_n;
			skip_q <= skip_n;
		end
	end

endmodule

// ----- src/protobuf_field_extractor.sv -----
// Protobuf wire-format field extractor, top level.
// A byte taken from msg waits in the input stage; its result, if any, is registered in the result register for res.
// One byte per cycle while res is not stalled; the parser makes a single state update per byte.
// A stalled res holds one byte in the input stage; msg stays ready while that stage is free.
// Reset (arst_n low, asynchronous): parser rearmed at the start of a message,
// both stages empty, target_field back to 3.
`include "protobuf_field_extractor_macros.svh"

module protobuf_field_extractor (
	input  logic            clk,
	input  logic            arst_n,
	pbfe_msg_if.sink        msg,
	pbfe_res_if.source      res,
	pbfe_cfg_if.sink        cfg
);

	// Input stage: one byte with its message length.
	logic            valid_s1;
	pbfe_pkg::item_t item_s1;

	// Result register facing res.
	logic              res_v_q;
	pbfe_pkg::result_t res_q;

	// Search target, written through cfg.
	logic [pbfe_pkg::FIELD_W-1:0] target_q;

	logic              advance;   // byte in the input stage is parsed this cycle
	logic              core_v;
	pbfe_pkg::result_t core_res;
	logic [pbfe_pkg::LEN_W:0] found_end;

	// The parser steps whenever the result register can take whatever it gives.
	assign advance   = valid_s1 && (!res_v_q || res.ready);
	assign msg.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.valid && msg.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready)
			item_s1 <= '{data_byte: msg.data_byte, message_length: msg.message_length};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= pbfe_pkg::TARGET_RESET;
		end else if (cfg.valid && cfg.ready) begin
			target_q <= cfg.target_field;
		end
	end

	// Key/length decoding, skips and the decision on the current byte.
	pbfe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.target (target_q),
		.res_v  (core_v),
		.res    (core_res)
	);

	// Result register: reloads in the same cycle the previous transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (advance && core_v) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_v)
			res_q <= core_res;
	end

	assign res.valid          = res_v_q;
	assign res.status         = res_q.status;
	assign res.payload_offset = res_q.payload_offset;
	assign res.payload_length = res_q.payload_length;

	// End of a found payload, one bit wider so it cannot wrap.
	assign found_end = (pbfe_pkg::LEN_W+1)'(core_res.payload_offset) +
		(pbfe_pkg::LEN_W+1)'(core_res.payload_length);

	// A byte waiting behind a stalled result is never dropped.
	`PBFE_ASSERT_NEXT(a_s1_kept, valid_s1 && res_v_q && !res.ready, valid_s1, "input stage byte lost while result stalled")
	// The result register is only loaded when it is free or being emptied.
	`PBFE_ASSERT_NOW(a_res_no_overwrite, advance && core_v, !res_v_q || res.ready, "result overwritten before transfer")
	// A found payload lies inside its message.
	`PBFE_ASSERT_NOW(a_found_in_msg, advance && core_v && core_res.status == pbfe_pkg::ST_FOUND, found_end <= (pbfe_pkg::LEN_W+1)'(item_s1.message_length), "found payload runs past message end")

endmodule
